// ===== hw/rtl/aws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aws_pkg
// shared types and constants of the acoustic wave stencil
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int unsigned MaxColumnsDef = 1024;
  localparam int unsigned SampleW       = 32;
  localparam int unsigned RowW          = 16;
  localparam int unsigned ColCountW     = 11;
  localparam int unsigned CntW          = 17;
  localparam int unsigned NumTaps       = 9;
  localparam int unsigned NumCoef       = 5;
  localparam int unsigned RowHist       = 4;
  localparam int unsigned PrevHist      = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_COEF_C     = 3'd1,
    CFG_COEF_VNEAR = 3'd2,
    CFG_COEF_VFAR  = 3'd3,
    CFG_COEF_HNEAR = 3'd4,
    CFG_COEF_HFAR  = 3'd5,
    CFG_COLS       = 3'd6,
    CFG_ROWS       = 3'd7
  } aws_cfg_e;

  // coefficient slots
  localparam int unsigned CoefC     = 0;
  localparam int unsigned CoefVNear = 1;
  localparam int unsigned CoefVFar  = 2;
  localparam int unsigned CoefHNear = 3;
  localparam int unsigned CoefHFar  = 4;

  // one column of line buffer history, index 0 is the newest row
  typedef struct packed {
    logic [RowHist-1:0][SampleW-1:0]  cur;
    logic [RowHist-1:0][SampleW-1:0]  vel;
    logic [PrevHist-1:0][SampleW-1:0] prv;
  } aws_col_t;

  typedef struct packed {
    logic emit;
    logic edge_col;
    logic last;
  } aws_ctl_t;

endpackage

// ===== hw/rtl/aws_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aws_line_mem
// column history memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module aws_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 320,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== hw/rtl/aws_stencil_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aws_stencil_pipe
// weighted stencil sum, velocity scaling, leapfrog update and saturation
// ----------------------------------------------------------------------------
module aws_stencil_pipe (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic [aws_pkg::NumTaps-1:0][aws_pkg::SampleW-1:0] u_i,
  input  logic [aws_pkg::NumTaps-1:0][aws_pkg::SampleW-1:0] v_i,
  input  logic [aws_pkg::SampleW-1:0]                       prev_i,
  input  aws_pkg::aws_ctl_t                                 ctl_i,
  input  logic [aws_pkg::NumCoef-1:0][aws_pkg::SampleW-1:0] coef_i,
  input  logic                                              mode_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [aws_pkg::SampleW-1:0]                       next_o,
  output logic                                              sat_o,
  output logic                                              last_o
);

  localparam int unsigned N  = aws_pkg::NumTaps;
  localparam int unsigned SW = aws_pkg::SampleW;
  localparam int unsigned NS = 7;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign in_ready_o = rdy[0];

  // stage a: operands
  logic [N-1:0][SW-1:0] a_u_q, a_v_q;
  logic [SW-1:0]        a_prev_q;
  aws_pkg::aws_ctl_t    a_ctl_q;
  // stage b: coefficient products
  logic signed [63:0]   b_p_q [N];
  logic [N-1:0][SW-1:0] b_v_q;
  logic [SW-1:0]        b_u0_q, b_prev_q;
  aws_pkg::aws_ctl_t    b_ctl_q;
  // stage c: rounded terms
  logic signed [35:0]   c_t_q [N];
  logic [N-1:0][SW-1:0] c_v_q;
  logic [SW-1:0]        c_u0_q, c_prev_q;
  aws_pkg::aws_ctl_t    c_ctl_q;
  // stage d: laplacian and per-term velocity products
  logic signed [39:0]   d_lap_q;
  logic signed [52:0]   d_ph_q [N];
  logic signed [52:0]   d_pl_q [N];
  logic [SW-1:0]        d_v0_q, d_u0_q, d_prev_q;
  aws_pkg::aws_ctl_t    d_ctl_q;
  // stage e: scaled terms
  logic signed [56:0]   e_lh_q, e_ll_q;
  logic signed [53:0]   e_s_q [N];
  logic [SW-1:0]        e_u0_q, e_prev_q;
  aws_pkg::aws_ctl_t    e_ctl_q;
  // stage f: velocity-scaled laplacian, or sum of scaled terms, by mode
  logic signed [59:0]   f_s_q;
  logic [SW-1:0]        f_u0_q, f_prev_q;
  aws_pkg::aws_ctl_t    f_ctl_q;
  // output register
  logic [SW-1:0]        g_next_q;
  logic                 g_sat_q, g_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NS - 1; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
      if (rdy[NS-1]) vld_q[NS-1] <= vld_q[NS-2] && f_ctl_q.emit;
    end
  end

  logic [N-1:0][SW-1:0] ksel;
  always_comb begin
    ksel[0] = coef_i[aws_pkg::CoefC];
    ksel[1] = coef_i[aws_pkg::CoefVNear];
    ksel[2] = coef_i[aws_pkg::CoefVNear];
    ksel[3] = coef_i[aws_pkg::CoefVFar];
    ksel[4] = coef_i[aws_pkg::CoefVFar];
    ksel[5] = coef_i[aws_pkg::CoefHNear];
    ksel[6] = coef_i[aws_pkg::CoefHNear];
    ksel[7] = coef_i[aws_pkg::CoefHFar];
    ksel[8] = coef_i[aws_pkg::CoefHFar];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_u_q    <= u_i;
      a_v_q    <= v_i;
      a_prev_q <= prev_i;
      a_ctl_q  <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < N; i++) begin
        b_p_q[i] <= $signed(a_u_q[i]) * $signed(ksel[i]);
      end
      b_v_q    <= a_v_q;
      b_u0_q   <= a_u_q[0];
      b_prev_q <= a_prev_q;
      b_ctl_q  <= a_ctl_q;
    end
  end

  // round half up by 2^28
  logic signed [63:0] b_rnd [N];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      b_rnd[i] = b_p_q[i] + 64'sd134217728;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < N; i++) begin
        c_t_q[i] <= b_rnd[i][63:28];
      end
      c_v_q    <= b_v_q;
      c_u0_q   <= b_u0_q;
      c_prev_q <= b_prev_q;
      c_ctl_q  <= b_ctl_q;
    end
  end

  logic signed [39:0] c_lap;
  always_comb begin
    c_lap = '0;
    for (int i = 0; i < N; i++) begin
      c_lap = c_lap + 40'(c_t_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      d_lap_q <= c_lap;
      for (int i = 0; i < N; i++) begin
        d_ph_q[i] <= c_t_q[i] * $signed({1'b0, c_v_q[i][31:16]});
        d_pl_q[i] <= c_t_q[i] * $signed({1'b0, c_v_q[i][15:0]});
      end
      d_v0_q   <= c_v_q[0];
      d_u0_q   <= c_u0_q;
      d_prev_q <= c_prev_q;
      d_ctl_q  <= c_ctl_q;
    end
  end

  // round half up by 2^16
  logic signed [52:0] d_plr [N];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      d_plr[i] = d_pl_q[i] + 53'sd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      e_lh_q <= d_lap_q * $signed({1'b0, d_v0_q[31:16]});
      e_ll_q <= d_lap_q * $signed({1'b0, d_v0_q[15:0]});
      for (int i = 0; i < N; i++) begin
        e_s_q[i] <= 54'(d_ph_q[i]) + 54'($signed(d_plr[i][52:16]));
      end
      e_u0_q   <= d_u0_q;
      e_prev_q <= d_prev_q;
      e_ctl_q  <= d_ctl_q;
    end
  end

  logic signed [56:0] e_llr;
  logic signed [59:0] e_sum, e_s;
  always_comb begin
    e_llr = e_ll_q + 57'sd32768;
    e_sum = '0;
    for (int i = 0; i < N; i++) begin
      e_sum = e_sum + 60'(e_s_q[i]);
    end
    e_s = mode_i ? 60'(e_lh_q) + 60'($signed(e_llr[56:16])) : e_sum;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      f_s_q    <= e_s;
      f_u0_q   <= e_u0_q;
      f_prev_q <= e_prev_q;
      f_ctl_q  <= e_ctl_q;
    end
  end

  logic signed [61:0] f_next;
  logic [SW-1:0]      f_res;
  logic               f_sat;
  always_comb begin
    f_next = (62'($signed(f_u0_q)) <<< 1) - 62'($signed(f_prev_q)) + 62'(f_s_q);
    f_sat  = 1'b0;
    if (f_ctl_q.edge_col) begin
      f_res = f_prev_q;
    end else if (f_next > 62'sd2147483647) begin
      f_res = {1'b0, {(SW-1){1'b1}}};
      f_sat = 1'b1;
    end else if (f_next < -62'sd2147483648) begin
      f_res = {1'b1, {(SW-1){1'b0}}};
      f_sat = 1'b1;
    end else begin
      f_res = f_next[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      g_next_q <= f_res;
      g_sat_q  <= f_sat;
      g_last_q <= f_ctl_q.last;
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign next_o      = g_next_q;
  assign sat_o       = g_sat_q;
  assign last_o      = g_last_q;

endmodule

// ===== hw/rtl/acoustic_wave_stencil_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acoustic_wave_stencil_2d
// leapfrog step of the 2-d acoustic wave equation, fourth-order laplacian
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata prev,cur,vel; tuser frame_start
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata next_sample; tuser saturated;
//                                                    tlast last_point
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one grid point per clock while m_axis does not stall; the figure is set by the
// read-modify-write of the column history memory, one column entry per beat
// reset clears counters and pipeline valids and sets config to defaults; memory has no clearing
// a stall on m_axis fills the pipeline bubbles before s_axis_tready drops
//
module acoustic_wave_stencil_2d #(
  parameter int unsigned MAX_COLUMNS = aws_pkg::MaxColumnsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // prev_sample, cur_sample, vel_term
  input  logic [0:0]  s_axis_tuser,  // frame_start
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // next_sample
  output logic [0:0]  m_axis_tuser,  // saturated
  output logic        m_axis_tlast,
  // config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned SW = aws_pkg::SampleW;
  localparam int unsigned CW = aws_pkg::CntW;
  localparam int unsigned RW = aws_pkg::RowW;
  localparam logic [CW-1:0] MaxCols = CW'(MAX_COLUMNS);

  // ---------------------------------------------------------------- config
  logic                                    mode_q;
  logic [aws_pkg::NumCoef-1:0][SW-1:0]     coef_q;
  logic [aws_pkg::ColCountW-1:0]           cols_q;
  logic [RW-1:0]                           rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      coef_q <= '0;
      cols_q <= aws_pkg::ColCountW'(1024);
      rows_q <= RW'(1024);
    end else if (cfg_valid_i) begin
      unique case (aws_pkg::aws_cfg_e'(cfg_index_i))
        aws_pkg::CFG_MODE:       mode_q <= cfg_data_i[0];
        aws_pkg::CFG_COEF_C:     coef_q[aws_pkg::CoefC] <= cfg_data_i;
        aws_pkg::CFG_COEF_VNEAR: coef_q[aws_pkg::CoefVNear] <= cfg_data_i;
        aws_pkg::CFG_COEF_VFAR:  coef_q[aws_pkg::CoefVFar] <= cfg_data_i;
        aws_pkg::CFG_COEF_HNEAR: coef_q[aws_pkg::CoefHNear] <= cfg_data_i;
        aws_pkg::CFG_COEF_HFAR:  coef_q[aws_pkg::CoefHFar] <= cfg_data_i;
        aws_pkg::CFG_COLS:       cols_q <= cfg_data_i[aws_pkg::ColCountW-1:0];
        aws_pkg::CFG_ROWS:       rows_q <= cfg_data_i[RW-1:0];
      endcase
    end
  end

  // clamped frame geometry
  logic [CW-1:0] cols_eff, rows_eff;
  always_comb begin
    cols_eff = CW'(cols_q);
    if (cols_eff < CW'(5)) cols_eff = CW'(5);
    else if (cols_eff > MaxCols) cols_eff = MaxCols;
    rows_eff = CW'(rows_q);
    if (rows_eff < CW'(5)) rows_eff = CW'(5);
  end

  // -------------------------------------------------------------- counters
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] col_q, col_d;
  logic          accept;
  logic [RW-1:0] r;
  logic [AW-1:0] c;
  logic [CW-1:0] r_w, c_w;
  aws_pkg::aws_ctl_t ctl_in;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    r   = s_axis_tuser[0] ? '0 : row_q;
    c   = s_axis_tuser[0] ? '0 : col_q;
    r_w = CW'(r);
    c_w = CW'(c);
    ctl_in.emit     = (r_w >= CW'(4)) && (r_w < rows_eff);
    ctl_in.edge_col = (c_w < CW'(2)) || (c_w + CW'(2) >= cols_eff);
    ctl_in.last     = (r_w == rows_eff - CW'(1)) && (c_w == cols_eff - CW'(1));
    // wrap at end of row and end of frame
    if (c_w + CW'(1) >= cols_eff) begin
      col_d = '0;
      row_d = (r_w + CW'(1) >= rows_eff) ? '0 : r + RW'(1);
    end else begin
      col_d = c + AW'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ------------------------------------------------- memory access stage
  logic              s1_v_q;
  aws_pkg::aws_ctl_t s1_ctl_q;
  logic [SW-1:0]     s1_prev_q, s1_cur_q, s1_vel_q;
  logic [AW-1:0]     s1_col_q;
  logic              pipe_ready, s1_move;
  aws_pkg::aws_col_t rd_a, rd_b, wr_col;
  logic [AW-1:0]     raddr_b;

  assign s1_move       = s1_v_q && pipe_ready;
  assign s_axis_tready = !s1_v_q || pipe_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_move) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q  <= ctl_in;
      s1_prev_q <= s_axis_tdata[31:0];
      s1_cur_q  <= s_axis_tdata[63:32];
      s1_vel_q  <= s_axis_tdata[95:64];
      s1_col_q  <= c;
    end
  end

  // read ahead two columns for the right-hand neighbours of row r-2;
  // edge centres never use it, so an address past the end reads entry 0
  assign raddr_b = (c_w + CW'(2) < MaxCols) ? c + AW'(2) : '0;

  // shift the new row into the column history
  always_comb begin
    wr_col.cur[0] = s1_cur_q;
    wr_col.vel[0] = s1_vel_q;
    for (int k = 1; k < aws_pkg::RowHist; k++) begin
      wr_col.cur[k] = rd_a.cur[k-1];
      wr_col.vel[k] = rd_a.vel[k-1];
    end
    wr_col.prv[0] = s1_prev_q;
    wr_col.prv[1] = rd_a.prv[0];
  end

  aws_line_mem #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH ($bits(aws_pkg::aws_col_t)),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (s1_move),
    .waddr_i   (s1_col_q),
    .wdata_i   (wr_col),
    .re_i      (accept),
    .raddr_a_i (c),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // row r-2 taps: two columns back from earlier beats, one ahead from the
  // previous read-ahead
  logic [SW-1:0] tap_cur_m1_q, tap_cur_m2_q, tap_cur_p1_q;
  logic [SW-1:0] tap_vel_m1_q, tap_vel_m2_q, tap_vel_p1_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      tap_cur_m1_q <= rd_a.cur[1];
      tap_cur_m2_q <= tap_cur_m1_q;
      tap_cur_p1_q <= rd_b.cur[1];
      tap_vel_m1_q <= rd_a.vel[1];
      tap_vel_m2_q <= tap_vel_m1_q;
      tap_vel_p1_q <= rd_b.vel[1];
    end
  end

  logic [aws_pkg::NumTaps-1:0][SW-1:0] st_u, st_v;
  always_comb begin
    st_u[0] = rd_a.cur[1];  st_v[0] = rd_a.vel[1];   // centre
    st_u[1] = tap_cur_m1_q; st_v[1] = tap_vel_m1_q;  // col c-1
    st_u[2] = tap_cur_p1_q; st_v[2] = tap_vel_p1_q;  // col c+1
    st_u[3] = tap_cur_m2_q; st_v[3] = tap_vel_m2_q;  // col c-2
    st_u[4] = rd_b.cur[1];  st_v[4] = rd_b.vel[1];   // col c+2
    st_u[5] = rd_a.cur[2];  st_v[5] = rd_a.vel[2];   // row r-3
    st_u[6] = rd_a.cur[0];  st_v[6] = rd_a.vel[0];   // row r-1
    st_u[7] = rd_a.cur[3];  st_v[7] = rd_a.vel[3];   // row r-4
    st_u[8] = s1_cur_q;     st_v[8] = s1_vel_q;      // row r
  end

  // ----------------------------------------------------------- arithmetic
  aws_stencil_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q),
    .in_ready_o  (pipe_ready),
    .u_i         (st_u),
    .v_i         (st_v),
    .prev_i      (rd_a.prv[1]),
    .ctl_i       (s1_ctl_q),
    .coef_i      (coef_q),
    .mode_i      (mode_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .next_o      (m_axis_tdata),
    .sat_o       (m_axis_tuser[0]),
    .last_o      (m_axis_tlast)
  );

`ifndef SYNTH
  // an empty access stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> s_axis_tready) else $error("input stalled with empty stage");

  // an accepted beat occupies the access stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q) else $error("accepted beat lost");

  // frame start restarts the counters at the first point
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser[0]) |=> (row_q == '0 && col_q == AW'(1)))
    else $error("frame start did not restart counters");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 2-d acoustic wave stencil: a 5x5 frame with
// hand-computed results, then frames of random size, weights and data,
// all checked against an in-bench predictor of the leapfrog step
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxCols  = aws_pkg::MaxColumnsDef;
  localparam int unsigned DrainCyc = 16;  // idle clocks that let the pipe empty after the last result

  typedef struct {
    bit [31:0] nxt;
    bit        sat;
    bit        lst;
  } wave_out_t;

  typedef struct {
    bit        fs;
    bit [31:0] prv;
    bit [31:0] cur;
    bit [31:0] vel;
    bit        chk;
    wave_out_t res;
  } point_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // prev_sample, cur_sample, vel_term
  logic [0:0]  s_axis_tuser = '0;  // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // next_sample
  logic [0:0]  m_axis_tuser;       // saturated
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  acoustic_wave_stencil_2d u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow configuration
  bit         vel_centre_mode = 1'b1;
  longint     coef_q28 [aws_pkg::NumCoef];
  bit [10:0]  cols_reg = 11'd1024;
  bit [15:0]  rows_reg = 16'd1024;

  // shadow line history and raster position
  bit [31:0]  cur_hist [aws_pkg::RowHist][MaxCols];
  bit [31:0]  vel_hist [aws_pkg::RowHist][MaxCols];
  bit [31:0]  prv_hist [aws_pkg::PrevHist][MaxCols];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  wave_out_t  next_q [$];
  int         err_cnt = 0;
  bit         quiet = 1'b0;  // no idling on either side near the end

  initial foreach (coef_q28[i]) coef_q28[i] = 0;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // coefficient times sample, rounded half up to the sample format
  function automatic longint rnd_coef(longint k, longint u);
    return (k * u + (64'sd1 <<< 27)) >>> 28;
  endfunction

  // value times unsigned q16.16 velocity term, rounded half up
  function automatic longint rnd_vel(longint x, bit [31:0] v);
    longint hi;
    longint lo;
    hi = longint'(v[31:16]);
    lo = longint'(v[15:0]);
    return x * hi + ((x * lo + (64'sd1 <<< 15)) >>> 16);
  endfunction

  function automatic longint sx(bit [31:0] v);
    return longint'($signed(v));
  endfunction

  // one leapfrog point; returns 1 when a centre result comes out
  function automatic bit step_wave(bit fs, bit [31:0] p, bit [31:0] cu, bit [31:0] ve,
                                   output wave_out_t res);
    int unsigned cols;
    int unsigned rows;
    int unsigned r;
    int unsigned c;
    int unsigned cs;
    longint      u [aws_pkg::NumTaps];
    bit [31:0]   v [aws_pkg::NumTaps];
    longint      k [aws_pkg::NumTaps];
    longint      s;
    longint      lap;
    longint      nx;
    longint      t;
    bit          emit;
    cols = cols_reg < 5 ? 5 : (cols_reg > MaxCols ? MaxCols : cols_reg);
    rows = rows_reg < 5 ? 5 : rows_reg;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    cs = (r - 2) & 3;
    emit = (r >= 4 && r < rows);
    res = '{default: 0};
    if (emit) begin
      nx = sx(prv_hist[r & 1][c]);
      if (c >= 2 && c + 2 < cols) begin
        u[0] = sx(cur_hist[cs][c]);         v[0] = vel_hist[cs][c];
        u[1] = sx(cur_hist[cs][c-1]);       v[1] = vel_hist[cs][c-1];
        u[2] = sx(cur_hist[cs][c+1]);       v[2] = vel_hist[cs][c+1];
        u[3] = sx(cur_hist[cs][c-2]);       v[3] = vel_hist[cs][c-2];
        u[4] = sx(cur_hist[cs][c+2]);       v[4] = vel_hist[cs][c+2];
        u[5] = sx(cur_hist[(r-3)&3][c]);    v[5] = vel_hist[(r-3)&3][c];
        u[6] = sx(cur_hist[(r-1)&3][c]);    v[6] = vel_hist[(r-1)&3][c];
        u[7] = sx(cur_hist[(r-4)&3][c]);    v[7] = vel_hist[(r-4)&3][c];
        u[8] = sx(cu);                      v[8] = ve;
        k[0] = coef_q28[aws_pkg::CoefC];
        k[1] = coef_q28[aws_pkg::CoefVNear]; k[2] = coef_q28[aws_pkg::CoefVNear];
        k[3] = coef_q28[aws_pkg::CoefVFar];  k[4] = coef_q28[aws_pkg::CoefVFar];
        k[5] = coef_q28[aws_pkg::CoefHNear]; k[6] = coef_q28[aws_pkg::CoefHNear];
        k[7] = coef_q28[aws_pkg::CoefHFar];  k[8] = coef_q28[aws_pkg::CoefHFar];
        s = 0;
        lap = 0;
        for (int i = 0; i < aws_pkg::NumTaps; i++) begin
          t = rnd_coef(k[i], u[i]);
          lap += t;
          s += rnd_vel(t, v[i]);
        end
        if (vel_centre_mode) s = rnd_vel(lap, v[0]);
        nx = 2 * u[0] - nx + s;
        if (nx > 64'sd2147483647) begin
          nx = 64'sd2147483647;
          res.sat = 1'b1;
        end else if (nx < -64'sd2147483648) begin
          nx = -64'sd2147483648;
          res.sat = 1'b1;
        end
      end
      res.nxt = nx[31:0];
      res.lst = (r == rows - 1 && c == cols - 1);
    end
    if (c < MaxCols) begin
      cur_hist[r & 3][c] = cu;
      vel_hist[r & 3][c] = ve;
      prv_hist[r & 1][c] = p;
    end
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return emit;
  endfunction

  // one input beat, with an occasional gap ahead of it
  task automatic push_point(bit fs, bit [31:0] p, bit [31:0] cu, bit [31:0] ve,
                            bit typed, wave_out_t typed_res);
    wave_out_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ve, cu, p};
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    if (step_wave(fs, p, cu, ve, pred)) next_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(aws_pkg::aws_cfg_e idx, bit [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      aws_pkg::CFG_MODE:       vel_centre_mode = val[0];
      aws_pkg::CFG_COEF_C:     coef_q28[aws_pkg::CoefC] = sx(val);
      aws_pkg::CFG_COEF_VNEAR: coef_q28[aws_pkg::CoefVNear] = sx(val);
      aws_pkg::CFG_COEF_VFAR:  coef_q28[aws_pkg::CoefVFar] = sx(val);
      aws_pkg::CFG_COEF_HNEAR: coef_q28[aws_pkg::CoefHNear] = sx(val);
      aws_pkg::CFG_COEF_HFAR:  coef_q28[aws_pkg::CoefHFar] = sx(val);
      aws_pkg::CFG_COLS:       cols_reg = val[10:0];
      aws_pkg::CFG_ROWS:       rows_reg = val[15:0];
    endcase
  endtask

  // hold off until every result is out and the pipe has emptied
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (next_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  // random word biased toward the extremes
  function automatic bit [31:0] pick_word(bit narrow);
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return narrow ? $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000 : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // result side: check each beat, stall in random bursts
  int unsigned ready_hold = 0;
  always @(posedge clk_i) begin
    wave_out_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (next_q.size() == 0) begin
        report($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want = next_q.pop_front();
        if (m_axis_tdata !== want.nxt)
          report($sformatf("next_sample %h, want %h", m_axis_tdata, want.nxt));
        if (m_axis_tuser[0] !== want.sat)
          report($sformatf("saturated %b, want %b", m_axis_tuser[0], want.sat));
        if (m_axis_tlast !== want.lst)
          report($sformatf("last_point %b, want %b", m_axis_tlast, want.lst));
      end
    end
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= $urandom_range(0, 1);
      ready_hold <= $urandom_range(1, 14);
    end
  end

  // 5x5 frame: only row 4 emits, centred on row 2; column 2 is the lone
  // interior point and with zero weights saturates high, the rest pass prev
  point_row_t dir_tab [25] = '{
    '{1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 0, '{0, 0, 0}},
    '{0, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000, 0, '{0, 0, 0}},
    '{0, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h0100_0000, 32'hff00_0000, 32'h0000_8000, 0, '{0, 0, 0}},
    '{0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 0, '{0, 0, 0}},
    '{0, 32'h0000_0001, 32'h0000_0000, 32'h1234_5678, 0, '{0, 0, 0}},
    '{0, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'hdead_beef, 32'h0bad_f00d, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0}},
    '{0, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '{0, 0, 0}},
    '{0, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000, 0, '{0, 0, 0}},
    '{0, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, '{0, 0, 0}},
    '{0, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 1, '{32'h0000_0001, 0, 0}},
    '{0, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 1, '{32'hffff_ffff, 0, 0}},
    '{0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1, '{32'h7fff_ffff, 1, 0}},
    '{0, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 1, '{32'h7fff_ffff, 0, 0}},
    '{0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1, '{32'h1234_5678, 0, 1}}
  };

  initial begin
    int unsigned rnd_items;
    int unsigned frame_no;
    int unsigned cols;
    int unsigned rows;
    int unsigned npts;
    int unsigned stop_at;
    bit          whole;
    bit          cut;
    bit [31:0]   cfg_cols;
    bit [31:0]   cfg_rows;
    wave_out_t   none;
    none = '{default: 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frame on reset weights and mode
    write_reg(aws_pkg::CFG_COLS, 32'd5);
    write_reg(aws_pkg::CFG_ROWS, 32'd5);
    foreach (dir_tab[i])
      push_point(dir_tab[i].fs, dir_tab[i].prv, dir_tab[i].cur, dir_tab[i].vel,
                 dir_tab[i].chk, dir_tab[i].res);

    // random frames; the first few pin the size extremes, the large ones
    // only for a short stretch
    rnd_items = 0;
    frame_no = 0;
    whole = 1'b1;
    while (rnd_items < 1600) begin
      drain_block();
      case (frame_no)
        0:       begin cfg_cols = 32'd2047; cfg_rows = 32'd5;     end
        1:       begin cfg_cols = 32'd0;    cfg_rows = 32'd0;     end
        2:       begin cfg_cols = 32'd5;    cfg_rows = 32'd65535; end
        3:       begin cfg_cols = 32'd1024; cfg_rows = 32'd6;     end
        default: begin
          cfg_cols = $urandom_range(0, 14);
          cfg_rows = $urandom_range(0, 10);
          if ($urandom_range(0, 9) == 0) cfg_cols |= 32'hffff_f800;
          if ($urandom_range(0, 9) == 0) cfg_rows |= 32'hffff_0000;
        end
      endcase
      write_reg(aws_pkg::CFG_MODE, frame_no < 2 ? 32'(frame_no) : 32'($urandom));
      write_reg(aws_pkg::CFG_COEF_C, pick_word(1'b0));
      write_reg(aws_pkg::CFG_COEF_VNEAR, pick_word(1'b0));
      write_reg(aws_pkg::CFG_COEF_VFAR, pick_word(1'b0));
      write_reg(aws_pkg::CFG_COEF_HNEAR, pick_word(1'b0));
      write_reg(aws_pkg::CFG_COEF_HFAR, pick_word(1'b0));
      write_reg(aws_pkg::CFG_COLS, cfg_cols);
      write_reg(aws_pkg::CFG_ROWS, cfg_rows);
      cols = cols_reg < 5 ? 5 : (cols_reg > MaxCols ? MaxCols : cols_reg);
      rows = rows_reg < 5 ? 5 : rows_reg;
      cut = (frame_no == 0 || frame_no == 2 || frame_no == 3);
      npts = cut ? 40 : cols * rows;
      // a broken frame stops early and is cut off by the next frame start
      stop_at = (frame_no > 3 && $urandom_range(0, 7) == 0) ? $urandom_range(1, npts) : npts;
      for (int i = 0; i < stop_at; i++) begin
        quiet = (rnd_items > 1400);
        push_point(i == 0 && (!whole || $urandom_range(0, 3) != 0),
                   pick_word(1'b1), pick_word(1'b1), pick_word(1'b0), 1'b0, none);
        rnd_items++;
      end
      whole = (stop_at == npts) && !cut;
      frame_no++;
    end
    s_axis_tvalid <= 1'b0;

    while (next_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
